/* sv/tlbit_pkg.sv */
// Package for the translation buffer: shared widths, defaults, codes and types.
// Used by the interfaces and by every module of the block; depends on nothing.
package tlbit_pkg;

    // Fixed field widths of the request and response channels.
    localparam int ADDR_W   = 48;
    localparam int SHIFT_W  = 5;
    localparam int RPA_W    = 40;
    localparam int STATUS_W = 3;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEF        = 32;
    localparam int VA_BITS_DEF        = 48;
    localparam int PA_BITS_DEF        = 40;
    localparam int MIN_PAGE_SHIFT_DEF = 12;
    localparam int MAX_PAGE_SHIFT_DEF = 30;

    // Reset value of the insert page shift register.
    localparam logic [SHIFT_W-1:0] INSERT_SHIFT_RESET = 5'd14;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Opcode values of a request.
    localparam logic OP_INSERT    = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_ALL_PINNED  = 3'd2,
        ST_NOT_PRESENT = 3'd3,
        ST_MISS        = 3'd4
    } status_t;

    // Classification that the front part attaches to a request.
    typedef enum logic [1:0] {
        KIND_TRANSLATE,
        KIND_INSERT,
        KIND_REJECT
    } kind_t;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOK,
        BK_COMMIT
    } bk_state_t;

    // One classified request as it travels through the queue.
    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   va;
        logic [ADDR_W-1:0]   pa;
        logic [SHIFT_W-1:0]  eps;
        logic [SHIFT_W-1:0]  ips;
        logic                entry_valid;
        logic                entry_fixed;
        logic                entry_present;
    } item_t;

    // Queue handshake toward the back part.
    typedef struct packed {
        logic  valid;
        item_t item;
    } pop_t;

    // Thermometer mask with every bit below n set.
    function automatic logic [63:0] keep_mask(input logic [6:0] n);
        logic [63:0] m;
        for (int i = 0; i < 64; i++)
        begin
            m[i] = (7'(i) < n);
        end
        return m;
    endfunction

endpackage

/* sv/tlbit_if.sv */
// Channel interfaces of the translation buffer: request and response.
// Depends on tlbit_pkg for the field widths.
interface tlbit_req_if import tlbit_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [ADDR_W-1:0]  virt_addr;
    logic [ADDR_W-1:0]  phys_addr;
    logic [SHIFT_W-1:0] page_shift;
    logic               entry_valid;
    logic               entry_fixed;
    logic               entry_present;

    modport source (output valid, opcode, virt_addr, phys_addr, page_shift,
                    entry_valid, entry_fixed, entry_present, input ready);
    modport sink   (input valid, opcode, virt_addr, phys_addr, page_shift,
                    entry_valid, entry_fixed, entry_present, output ready);
endinterface

interface tlbit_resp_if import tlbit_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RPA_W-1:0]    result_phys_addr;

    modport source (output valid, status, result_phys_addr, input ready);
    modport sink   (input valid, status, result_phys_addr, output ready);
endinterface

/* sv/tlb_insert_and_translate_core.sv */
// Top level of the translation buffer: config register, front, queue and back.
// Depends on tlbit_pkg, tlbit_if, tlbit_front, tlbit_queue and tlbit_back.
//
// Usage: requests arrive on req (valid/ready). Opcode zero inserts an entry,
// opcode one translates virt_addr. Each request gives exactly one response on
// resp with a status and, for a successful translate, the physical address.
// The insert page shift register is written through cfg_we/cfg_wdata and is
// read at the time a request is accepted.
// A request passes through the queue, then the back part's look state, which
// registers the compare over all entries, and its commit state, which chooses
// the slot, writes the entry and loads the response register. The back part
// works on one request at a time and takes the next as it commits the last.
// A two-entry queue keeps accepting requests while the back part works, and
// the response register keeps its value while resp.ready is low; the back
// part then waits and the queue fills before req.ready drops.
// Reset clears all entry flags, the victim pointer and the queues, and sets
// the insert page shift to 14; no clearing pass is needed.
module tlb_insert_and_translate_core import tlbit_pkg::*; #(
    parameter int ENTRIES        = ENTRIES_DEF,
    parameter int VA_BITS        = VA_BITS_DEF,
    parameter int PA_BITS        = PA_BITS_DEF,
    parameter int MIN_PAGE_SHIFT = MIN_PAGE_SHIFT_DEF,
    parameter int MAX_PAGE_SHIFT = MAX_PAGE_SHIFT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    tlbit_req_if.sink          req,
    tlbit_resp_if.source       resp,
    input  logic               cfg_we,
    input  logic [SHIFT_W-1:0] cfg_wdata
);

    logic [SHIFT_W-1:0] insert_page_shift_reg;
    logic               q_push_valid;
    logic               q_push_ready;
    item_t              q_push_item;
    pop_t               q_pop;
    logic               q_pop_ready;

    // Insert page shift register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insert_page_shift_reg <= INSERT_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            insert_page_shift_reg <= cfg_wdata;
        end
    end

    tlbit_front #(
        .VA_BITS        (VA_BITS),
        .PA_BITS        (PA_BITS),
        .MIN_PAGE_SHIFT (MIN_PAGE_SHIFT),
        .MAX_PAGE_SHIFT (MAX_PAGE_SHIFT)
    ) u_front (
        .req               (req),
        .insert_page_shift (insert_page_shift_reg),
        .push_ready        (q_push_ready),
        .push_valid        (q_push_valid),
        .push_item         (q_push_item)
    );

    tlbit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_item  (q_push_item),
        .push_ready (q_push_ready),
        .pop_ready  (q_pop_ready),
        .pop        (q_pop)
    );

    tlbit_back #(
        .ENTRIES        (ENTRIES),
        .VA_BITS        (VA_BITS),
        .PA_BITS        (PA_BITS),
        .MIN_PAGE_SHIFT (MIN_PAGE_SHIFT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (q_pop),
        .pop_ready (q_pop_ready),
        .resp      (resp)
    );

    // A failed request never carries an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && (resp.status != ST_OK) |-> resp.result_phys_addr == '0)
        else $error("address returned with a failing status");

    // Back pressure on requests only comes from a queue that holds items.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> q_pop.valid)
        else $error("request stalled while the queue is empty");

endmodule

/* sv/tlbit_front.sv */
// Front part: accepts requests and checks insert parameters before queueing.
// Depends on tlbit_pkg and tlbit_req_if.
module tlbit_front import tlbit_pkg::*; #(
    parameter int VA_BITS        = VA_BITS_DEF,
    parameter int PA_BITS        = PA_BITS_DEF,
    parameter int MIN_PAGE_SHIFT = MIN_PAGE_SHIFT_DEF,
    parameter int MAX_PAGE_SHIFT = MAX_PAGE_SHIFT_DEF
) (
    tlbit_req_if.sink          req,
    input  logic [SHIFT_W-1:0] insert_page_shift,
    input  logic               push_ready,
    output logic               push_valid,
    output item_t              push_item
);

    logic [63:0]       ips_keep;
    logic [63:0]       va_keep;
    logic [63:0]       pa_keep;
    logic [63:0]       min_keep;
    logic [ADDR_W-1:0] pa_page;
    logic              bad;

    // Parameter checks of an insert request.
    always_comb
    begin
        ips_keep = keep_mask(7'(insert_page_shift));
        va_keep  = keep_mask(7'(VA_BITS));
        pa_keep  = keep_mask(7'(PA_BITS));
        min_keep = keep_mask(7'(MIN_PAGE_SHIFT));
        pa_page  = req.phys_addr & ~min_keep[ADDR_W-1:0];
        bad = (int'(insert_page_shift) > MAX_PAGE_SHIFT)
           || ((req.virt_addr & ips_keep[ADDR_W-1:0]) != '0)
           || ((req.virt_addr & ~va_keep[ADDR_W-1:0]) != '0)
           || ((pa_page & ips_keep[ADDR_W-1:0]) != '0)
           || ((pa_page & ~pa_keep[ADDR_W-1:0]) != '0)
           || (int'(req.page_shift) < MIN_PAGE_SHIFT)
           || (int'(req.page_shift) > MAX_PAGE_SHIFT);
    end

    // Build the classified item.
    always_comb
    begin
        if (req.opcode == OP_TRANSLATE)
        begin
            push_item.kind = KIND_TRANSLATE;
        end
        else if (bad)
        begin
            push_item.kind = KIND_REJECT;
        end
        else
        begin
            push_item.kind = KIND_INSERT;
        end
        push_item.va            = req.virt_addr;
        push_item.pa            = pa_page;
        push_item.eps           = req.page_shift;
        push_item.ips           = insert_page_shift;
        push_item.entry_valid   = req.entry_valid;
        push_item.entry_fixed   = req.entry_fixed;
        push_item.entry_present = req.entry_present;
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

/* sv/tlbit_queue.sv */
// Short request queue between the front and back parts.
// Depends on tlbit_pkg for the item type and depth.
module tlbit_queue import tlbit_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop_ready,
    output pop_t  pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;
    assign pop.valid  = (count_reg != '0);
    assign pop.item   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/tlbit_back.sv */
// Back part: entry storage, associative match, replacement and the response register.
// Depends on tlbit_pkg and tlbit_resp_if.
module tlbit_back import tlbit_pkg::*; #(
    parameter int ENTRIES        = ENTRIES_DEF,
    parameter int VA_BITS        = VA_BITS_DEF,
    parameter int PA_BITS        = PA_BITS_DEF,
    parameter int MIN_PAGE_SHIFT = MIN_PAGE_SHIFT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  pop_t         pop,
    output logic         pop_ready,
    tlbit_resp_if.source resp
);

    localparam int IW     = $clog2(ENTRIES);
    localparam int VA_EFF = (VA_BITS < ADDR_W) ? VA_BITS : ADDR_W;
    localparam int PA_EFF = (PA_BITS < ADDR_W) ? PA_BITS : ADDR_W;
    localparam int VPW    = VA_EFF - MIN_PAGE_SHIFT;
    localparam int PPW    = PA_EFF - MIN_PAGE_SHIFT;

    // Entry storage; the flag vectors are cleared by reset.
    logic [VPW-1:0]     vpage_reg [ENTRIES];
    logic [PPW-1:0]     ppage_reg [ENTRIES];
    logic [SHIFT_W-1:0] shift_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] pinned_reg, pinned_next;
    logic [ENTRIES-1:0] present_reg, present_next;
    logic [IW-1:0]      victim_reg, victim_next;

    bk_state_t          state_reg, state_next;
    item_t              item_reg;
    logic [ENTRIES-1:0] match_reg, match_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [RPA_W-1:0]    out_pa_reg;
    logic                out_free;
    logic                take;
    logic                commit;

    logic [ENTRIES-1:0]  free_vec;
    logic [ENTRIES-1:0]  avail_hi;
    logic                have_free;
    logic                have_rr;
    logic [IW-1:0]       cand;
    logic                do_write;
    status_t             status_c;
    logic [RPA_W-1:0]    pa_c;

    function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    assign out_free = !out_valid_reg || resp.ready;

    // Sequencer next state.
    always_comb
    begin
        unique case (state_reg)
            BK_IDLE:   state_next = pop.valid ? BK_LOOK : BK_IDLE;
            BK_LOOK:   state_next = BK_COMMIT;
            BK_COMMIT: state_next = !out_free ? BK_COMMIT
                                  : (pop.valid ? BK_LOOK : BK_IDLE);
            default:   state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                commit    = 1'b0;
            end
            BK_COMMIT:
            begin
                pop_ready = out_free;
                commit    = out_free;
            end
            default:
            begin
                pop_ready = 1'b0;
                commit    = 1'b0;
            end
        endcase
    end

    assign take = pop.valid && pop_ready;

    // Associative compare over all entries, one compare per entry.
    always_comb
    begin
        logic [63:0]       ikeep;
        logic [63:0]       skeep;
        logic [ADDR_W-1:0] imask;
        logic [ADDR_W-1:0] full;
        ikeep = keep_mask(7'(item_reg.ips));
        imask = (item_reg.kind == KIND_TRANSLATE) ? '1 : ~ikeep[ADDR_W-1:0];
        for (int i = 0; i < ENTRIES; i++)
        begin
            skeep = keep_mask(7'(shift_reg[i]));
            full  = ADDR_W'({vpage_reg[i], {MIN_PAGE_SHIFT{1'b0}}});
            match_next[i] = valid_reg[i]
                && (((full ^ item_reg.va) & ~skeep[ADDR_W-1:0] & imask) == '0);
        end
    end

    // Slot choice for an insert: first free or cleared, else round robin.
    always_comb
    begin
        free_vec  = ~valid_reg | match_reg;
        have_free = |free_vec;
        avail_hi  = ~pinned_reg & ({ENTRIES{1'b1}} << victim_reg);
        have_rr   = |(~pinned_reg);
        if (have_free)
        begin
            cand = first_set(free_vec);
        end
        else if (|avail_hi)
        begin
            cand = first_set(avail_hi);
        end
        else
        begin
            cand = first_set(~pinned_reg);
        end
    end

    // Result of the current item.
    always_comb
    begin
        logic [IW-1:0]     hidx;
        logic [63:0]       skeep;
        logic [63:0]       pkeep;
        logic [ADDR_W-1:0] pfull;
        logic [ADDR_W-1:0] pm;
        logic [ADDR_W-1:0] pa_w;
        hidx  = first_set(match_reg);
        skeep = keep_mask(7'(shift_reg[hidx]));
        pkeep = keep_mask(7'(PA_BITS));
        pm    = ~skeep[ADDR_W-1:0];
        pfull = ADDR_W'({ppage_reg[hidx], {MIN_PAGE_SHIFT{1'b0}}});
        pa_w  = ((pfull & pm) | (item_reg.va & ~pm)) & pkeep[ADDR_W-1:0];
        pa_c  = '0;
        do_write = 1'b0;
        case (item_reg.kind)
            KIND_TRANSLATE:
            begin
                if (!(|match_reg))
                begin
                    status_c = ST_MISS;
                end
                else if (!present_reg[hidx])
                begin
                    status_c = ST_NOT_PRESENT;
                end
                else
                begin
                    status_c = ST_OK;
                    pa_c     = pa_w[RPA_W-1:0];
                end
            end
            KIND_INSERT:
            begin
                if (have_free || have_rr)
                begin
                    status_c = ST_OK;
                    do_write = 1'b1;
                end
                else
                begin
                    status_c = ST_ALL_PINNED;
                end
            end
            default:
            begin
                status_c = ST_INVALID;
            end
        endcase
    end

    // Flag and victim pointer updates of an insert.
    always_comb
    begin
        valid_next   = valid_reg;
        pinned_next  = pinned_reg;
        present_next = present_reg;
        victim_next  = victim_reg;
        if (commit && do_write)
        begin
            valid_next  = valid_reg & ~match_reg;
            pinned_next = pinned_reg & ~match_reg;
            valid_next[cand]   = item_reg.entry_valid;
            pinned_next[cand]  = item_reg.entry_fixed;
            present_next[cand] = item_reg.entry_present;
            if (!have_free)
            begin
                victim_next = (cand == IW'(ENTRIES - 1)) ? '0 : cand + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            pinned_reg    <= '0;
            present_reg   <= '0;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            pinned_reg  <= pinned_next;
            present_reg <= present_next;
            victim_reg  <= victim_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: current item, match vector, entry fields, response.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= pop.item;
        end
        if (state_reg == BK_LOOK)
        begin
            match_reg <= match_next;
        end
        if (commit && do_write)
        begin
            vpage_reg[cand] <= item_reg.va[MIN_PAGE_SHIFT +: VPW];
            ppage_reg[cand] <= item_reg.pa[MIN_PAGE_SHIFT +: PPW];
            shift_reg[cand] <= item_reg.eps;
        end
        if (commit)
        begin
            out_status_reg <= status_c;
            out_pa_reg     <= pa_c;
        end
    end

    assign resp.valid            = out_valid_reg;
    assign resp.status           = out_status_reg;
    assign resp.result_phys_addr = out_pa_reg;

endmodule

/* sim/tlb_insert_and_translate_core_tb.sv */
// Self-checking testbench for the translation buffer top level.
// Predicts every response from its own copy of the entry table and compares
// field by field; depends on tlbit_pkg, tlbit_if and the block's RTL.
class tlb_scoreboard;
    // Predicted entry table and configuration.
    bit [35:0] vpage [32];
    bit [27:0] ppage [32];
    bit [4:0]  pshift [32];
    bit        v_flag [32];
    bit        pin_flag [32];
    bit        pres_flag [32];
    int        rr_ptr;
    bit [4:0]  ins_shift;
    bit [42:0] pending [$];
    int        errors;

    function new();
        for (int i = 0; i < 32; i++)
        begin
            v_flag[i] = 0;
            pin_flag[i] = 0;
            pres_flag[i] = 0;
            vpage[i] = 0;
            ppage[i] = 0;
            pshift[i] = 0;
        end
        rr_ptr = 0;
        ins_shift = tlbit_pkg::INSERT_SHIFT_RESET;
        errors = 0;
    endfunction

    static function bit [63:0] lmask(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Insert: checks, overlap clearing, slot choice, entry write.
    function tlbit_pkg::status_t insert_entry(bit [47:0] va_in, bit [47:0] pa_in,
                                              bit [4:0] eps, bit ev, bit ef, bit ep);
        bit [63:0] va, pa, imask, tva, cmask;
        int cand;
        bit have;
        va = {16'd0, va_in};
        pa = {16'd0, pa_in} & ~lmask(12);
        have = 0;
        cand = 0;
        if (ins_shift > 30) return tlbit_pkg::ST_INVALID;
        imask = ~lmask(int'(ins_shift));
        if ((va & imask) != va || (va & lmask(48)) != va) return tlbit_pkg::ST_INVALID;
        if ((pa & imask) != pa || (pa & lmask(40)) != pa) return tlbit_pkg::ST_INVALID;
        if (eps < 12 || eps > 30) return tlbit_pkg::ST_INVALID;
        for (int i = 0; i < 32; i++)
        begin
            if (!v_flag[i])
            begin
                if (!have) begin cand = i; have = 1; end
                continue;
            end
            tva = {16'd0, vpage[i], 12'd0};
            cmask = ~lmask(int'(pshift[i])) & imask;
            if ((tva & cmask) == (va & cmask))
            begin
                v_flag[i] = 0;
                pin_flag[i] = 0;
                if (!have) begin cand = i; have = 1; end
            end
        end
        if (!have)
        begin
            for (int i = 0; i < 32; i++)
            begin
                if (!have && !pin_flag[(rr_ptr + i) % 32])
                begin
                    cand = (rr_ptr + i) % 32;
                    have = 1;
                end
            end
            if (!have) return tlbit_pkg::ST_ALL_PINNED;
            rr_ptr = (cand + 1) % 32;
        end
        vpage[cand] = va[47:12];
        ppage[cand] = pa[39:12];
        pshift[cand] = eps;
        v_flag[cand] = ev;
        pin_flag[cand] = ef;
        pres_flag[cand] = ep;
        return tlbit_pkg::ST_OK;
    endfunction

    // Note an accepted request and queue its predicted response.
    function void note_request(bit op, bit [47:0] va, bit [47:0] pa, bit [4:0] eps,
                               bit ev, bit ef, bit ep);
        tlbit_pkg::status_t st;
        bit [63:0] pm, tva, res;
        res = 0;
        if (op == tlbit_pkg::OP_INSERT)
            st = insert_entry(va, pa, eps, ev, ef, ep);
        else
        begin
            st = tlbit_pkg::ST_MISS;
            for (int i = 0; i < 32; i++)
            begin
                if (st != tlbit_pkg::ST_MISS || !v_flag[i]) continue;
                pm = ~lmask(int'(pshift[i]));
                tva = {16'd0, vpage[i], 12'd0};
                if ((tva & pm) != ({16'd0, va} & pm)) continue;
                if (!pres_flag[i])
                    st = tlbit_pkg::ST_NOT_PRESENT;
                else
                begin
                    st = tlbit_pkg::ST_OK;
                    res = (({36'd0, ppage[i]} << 12) & pm) | ({16'd0, va} & ~pm);
                    res &= lmask(40);
                end
            end
        end
        pending.push_back({st, res[39:0]});
    endfunction

    // Compare one response with the oldest prediction.
    function void check_response(bit [2:0] st, bit [39:0] pa);
        bit [42:0] e;
        if (pending.size() == 0)
        begin
            $error("unexpected response status=%0d pa=%h", st, pa);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e[42:40] != st)
        begin
            $error("status: expected %0d actual %0d", e[42:40], st);
            errors++;
        end
        if (e[39:0] != pa)
        begin
            $error("result_phys_addr: expected %h actual %h", e[39:0], pa);
            errors++;
        end
    endfunction
endclass

module tlb_insert_and_translate_core_tb;
    import tlbit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [SHIFT_W-1:0] cfg_wdata = '0;
    bit quiet = 0;
    tlb_scoreboard sb = new();
    bit [47:0] known_va [$];

    tlbit_req_if req ();
    tlbit_resp_if resp ();

    tlb_insert_and_translate_core DUT (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .resp(resp.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        req.valid = 0;
        req.opcode = 0;
        req.virt_addr = '0;
        req.phys_addr = '0;
        req.page_shift = '0;
        req.entry_valid = 0;
        req.entry_fixed = 0;
        req.entry_present = 0;
        resp.ready = 0;
    end

    // Sample accepted requests and responses at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.opcode, req.virt_addr, req.phys_addr, req.page_shift,
                            req.entry_valid, req.entry_fixed, req.entry_present);
        if (rst_n && resp.valid && resp.ready)
            sb.check_response(resp.status, resp.result_phys_addr);
    end

    // Response side stalls in random bursts.
    always @(negedge clk)
    begin
        if (quiet || $urandom_range(0, 3) != 0)
            resp.ready <= 1;
        else
        begin
            resp.ready <= 0;
            repeat ($urandom_range(0, 14)) @(negedge clk);
        end
    end

    // Present one request and hold it until accepted.
    task automatic send_request(bit op, bit [47:0] va, bit [47:0] pa, bit [4:0] eps,
                                bit ev, bit ef, bit ep);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req.valid <= 1;
        req.opcode <= op;
        req.virt_addr <= va;
        req.phys_addr <= pa;
        req.page_shift <= eps;
        req.entry_valid <= ev;
        req.entry_fixed <= ef;
        req.entry_present <= ep;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Wait for all responses, then let the pipeline settle.
    task automatic drain();
        req.valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_insert_shift(bit [4:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.ins_shift = v;
    endtask

    function automatic bit pin_pk(bit pin_ok);
        return pin_ok && $urandom_range(0, 5) == 0;
    endfunction

    // Well-formed insert aligned to the current insert page size.
    task automatic good_insert(bit pin_ok);
        bit [4:0] s, eps;
        bit [47:0] va, pa;
        s = (sb.ins_shift < 12) ? 5'd12 : sb.ins_shift;
        eps = 5'($urandom_range(12, 30));
        va = 48'({$urandom, $urandom}) & ~((48'd1 << s) - 1);
        pa = 48'({$urandom, $urandom}) & 48'hFF_FFFF_FFFF & ~((48'd1 << s) - 1);
        if ($urandom_range(0, 2) == 0) va[47:20] = 0;
        known_va.push_back(va);
        send_request(OP_INSERT, va, pa, eps, $urandom_range(0, 7) != 0,
                     pin_pk(pin_ok), $urandom_range(0, 4) != 0);
    endtask

    task automatic good_translate();
        bit [47:0] va;
        va = known_va.size() ? known_va[$urandom_range(0, known_va.size() - 1)]
                             : 48'({$urandom, $urandom});
        va ^= $urandom_range(0, 3) ? 48'($urandom & 32'h3FFF_FFFF) : 48'($urandom);
        send_request(OP_TRANSLATE, va, 48'({$urandom, $urandom}), 5'($urandom),
                     1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic noise_request();
        send_request(1'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     5'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial
    begin
        bit [4:0] shifts [6];
        shifts = '{5'd12, 5'd30, 5'd31, 5'd0, 5'd21, 5'd14};
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: field extremes, bad parameters, flag combinations.
        send_request(OP_INSERT, 48'h0, 48'h0, 5'd12, 1, 0, 1);
        send_request(OP_TRANSLATE, 48'h0000_0000_0ABC, '0, '0, 0, 0, 0);
        send_request(OP_TRANSLATE, '1, '1, '1, 1, 1, 1);
        send_request(OP_INSERT, 48'hFFFF_FFFF_C000, 48'hFF_FFFF_C000, 5'd30, 1, 0, 1);
        send_request(OP_TRANSLATE, '1, '0, '0, 0, 0, 0);
        send_request(OP_INSERT, 48'h1000, 48'h0, 5'd12, 1, 0, 1);
        send_request(OP_INSERT, 48'h4000, 48'hFFFF_FFFF_C000, 5'd12, 1, 0, 1);
        send_request(OP_INSERT, 48'h4000, 48'h2FFF, 5'd12, 1, 0, 1);
        send_request(OP_INSERT, 48'h4000, 48'h8000, 5'd11, 1, 0, 1);
        send_request(OP_INSERT, 48'h4000, 48'h8000, 5'd31, 1, 0, 1);
        send_request(OP_INSERT, 48'h8000, 48'hC000, 5'd14, 1, 1, 0);
        send_request(OP_TRANSLATE, 48'h8123, '0, '0, 0, 0, 0);
        send_request(OP_INSERT, 48'hC000, 48'h10000, 5'd14, 0, 0, 1);
        send_request(OP_TRANSLATE, 48'hC123, '0, '0, 0, 0, 0);
        send_request(OP_INSERT, 48'h0, 48'h40000, 5'd20, 1, 0, 1);
        send_request(OP_TRANSLATE, 48'h8FFF, '0, '0, 0, 0, 0);

        // Fill every slot pinned, then hit the all-pinned case.
        for (int i = 0; i < 33; i++)
            send_request(OP_INSERT, 48'(i + 100) << 14, 48'(i) << 14, 5'd14, 1, 1, 1);
        // Sender holds off until every response has come.
        drain();
        send_request(OP_TRANSLATE, 48'd105 << 14, '0, '0, 0, 0, 0);

        // Random phases over several insert page sizes.
        for (int p = 0; p < 6; p++)
        begin
            write_insert_shift(shifts[p]);
            for (int n = 0; n < 100; n++)
            begin
                if (p == 5 && n == 60) quiet = 1;
                case ($urandom_range(0, 9))
                    0: noise_request();
                    1, 2, 3, 4: good_insert(1);
                    default: good_translate();
                endcase
            end
        end
        drain();
        if (sb.errors == 0)
            $display("tlb_insert_and_translate_core verification clean");
        else
            $display("tlb_insert_and_translate_core verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tlb_insert_and_translate_core verification failed");
        $finish;
    end
endmodule
